[design/v2au_pkg.sv]
// Shared types, constants and the arctangent table of the 2D vector unit.
`timescale 1ns / 1ps
package v2au_pkg;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_NEG    = 3'd2,
        OP_SCALE  = 3'd3,
        OP_LENGTH = 3'd4,
        OP_ROTATE = 3'd5
    } op_t;

    localparam int XW     = 40;   // CORDIC vector width incl. guard bits
    localparam int ZW     = 34;   // residual angle width
    localparam int VW     = 49;   // pre-clamp result width
    localparam int GUARD  = 4;
    localparam int NCELLS = 32;   // one square-root bit per cell
    localparam logic signed [24:0] GAIN_INV = 25'sd10188012;

    typedef struct packed {
        op_t                   op;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic [63:0]           n;
        logic [63:0]           r;
        logic signed [31:0]    bx;
        logic signed [31:0]    by;
    } stage_t;

    typedef struct packed {
        logic signed [VW-1:0]  vx;
        logic signed [VW-1:0]  vy;
        logic signed [31:0]    bx;
        logic signed [31:0]    by;
    } fin_t;

    // arctangent of 2^-k in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            5'd30: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

[design/vector_2d_arithmetic_unit.sv]
// Top level of the 2D vector arithmetic unit: input stages, cell chain, output stages.
//
//  channel | dir | word
//  s_*     | in  | tdata: ax, ay, bx, by, scale_factor, angle; tuser: operation
//  m_*     | out | tdata: result_x, result_y; tuser: saturated
//
// One word enters per cycle while no stage is held by back-pressure; each word passes two input stages,
// 32 chain cells (one square-root bit each, one CORDIC step in the first
// ITERATIONS cells) and two output stages. Every stage has its own valid bit,
// so bubbles close up under back-pressure. Reset clears only the valid bits.
`timescale 1ns / 1ps
module vector_2d_arithmetic_unit
    import v2au_pkg::*;
#(
    parameter int ITERATIONS = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // ax, ay, bx, by, scale_factor, angle
    input  logic [2:0]    s_tuser,   // operation
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // result_x, result_y
    output logic          m_tuser    // saturated
);

    logic   cv [0:NCELLS];
    logic   cr [0:NCELLS];
    stage_t cd [0:NCELLS];

    v2au_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .operation (s_tuser),
        .operands  (s_tdata),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        v2au_cell #(
            .IDX        (i),
            .ITERATIONS (ITERATIONS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_data  (cd[i+1])
        );
    end

    v2au_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[NCELLS]),
        .in_ready  (cr[NCELLS]),
        .in_data   (cd[NCELLS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_xy    (m_tdata),
        .out_sat   (m_tuser)
    );

    // an empty output stage lets the whole chain move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // hold the output word while the receiver stalls
    a_output_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output word changed under stall");

    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cv[NCELLS] && !cr[NCELLS]) |=> cv[NCELLS])
        else $error("chain tail dropped a word under stall");

endmodule

[design/v2au_prep.sv]
// Input stages: operand setup, products, quadrant turn and sum of squares.
`timescale 1ns / 1ps
module v2au_prep
    import v2au_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    operation,
    input  logic [191:0]  operands,
    output logic          out_valid,
    input  logic          out_ready,
    output stage_t        out_data
);

    logic               v1_reg, v2_reg;
    stage_t             s1_reg, s1_next, s2_reg, s2_next;
    logic               rdy1, rdy2;
    logic signed [31:0] ax, ay, bx, by, sc;
    logic [31:0]        angle, resid;
    logic [1:0]         quad;
    logic signed [32:0] ax33, ay33, bx33, by33, dx, dy, ma_x, ma_y, mb_x, mb_y;
    logic signed [33:0] rx0, ry0;
    logic signed [65:0] px, py;

    assign ax    = operands[31:0];
    assign ay    = operands[63:32];
    assign bx    = operands[95:64];
    assign by    = operands[127:96];
    assign sc    = operands[159:128];
    assign angle = operands[191:160];
    assign ax33  = 33'(ax);
    assign ay33  = 33'(ay);
    assign bx33  = 33'(bx);
    assign by33  = 33'(by);
    assign dx    = ax33 - bx33;
    assign dy    = ay33 - by33;
    assign quad  = 2'((angle + 32'h20000000) >> 30);
    assign resid = angle - {quad, 30'd0};

    // one multiplier per axis: scale products or squares of magnitudes
    always_comb
    begin
        if (op_t'(operation) == OP_LENGTH)
        begin
            ma_x = ax[31] ? -ax33 : ax33;
            ma_y = ay[31] ? -ay33 : ay33;
            mb_x = ma_x;
            mb_y = ma_y;
        end
        else
        begin
            ma_x = ax33;
            ma_y = ay33;
            mb_x = 33'(sc);
            mb_y = 33'(sc);
        end
    end

    assign px = ma_x * mb_x;
    assign py = ma_y * mb_y;

    always_comb
    begin
        case (quad)
            2'd1:    begin rx0 = -34'(dy); ry0 = 34'(dx);  end
            2'd2:    begin rx0 = -34'(dx); ry0 = -34'(dy); end
            2'd3:    begin rx0 = 34'(dy);  ry0 = -34'(dx); end
            default: begin rx0 = 34'(dx);  ry0 = 34'(dy);  end
        endcase
    end

    always_comb
    begin
        s1_next    = '0;
        s1_next.op = op_t'(operation);
        s1_next.bx = bx;
        s1_next.by = by;
        case (op_t'(operation))
            OP_ADD:
            begin
                s1_next.x = XW'(ax33 + bx33);
                s1_next.y = XW'(ay33 + by33);
            end
            OP_SUB:
            begin
                s1_next.x = XW'(dx);
                s1_next.y = XW'(dy);
            end
            OP_NEG:
            begin
                s1_next.x = XW'(-ax33);
                s1_next.y = XW'(-ay33);
            end
            OP_SCALE, OP_LENGTH:
            begin
                s1_next.n = px[63:0];
                s1_next.r = py[63:0];
            end
            OP_ROTATE:
            begin
                s1_next.x = XW'(rx0) <<< GUARD;
                s1_next.y = XW'(ry0) <<< GUARD;
                s1_next.z = ZW'($signed(resid));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        s2_next = s1_reg;
        if (s1_reg.op == OP_LENGTH)
        begin
            s2_next.n = s1_reg.n + s1_reg.r;
            s2_next.r = '0;
        end
    end

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            s1_reg <= s1_next;
        if (rdy2 && v1_reg)
            s2_reg <= s2_next;
    end

    assign out_valid = v2_reg;
    assign out_data  = s2_reg;

endmodule

[design/v2au_cell.sv]
// One chain cell: a CORDIC micro-rotation (only while IDX < ITERATIONS) and one square-root bit.
`timescale 1ns / 1ps
module v2au_cell
    import v2au_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int ITERATIONS = 24
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  stage_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output stage_t  out_data
);

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * IDX);

    logic                 v_reg;
    stage_t               d_reg, d_next;
    logic                 rdy;
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic [63:0]          trial;

    assign xs    = in_data.x >>> IDX;
    assign ys    = in_data.y >>> IDX;
    assign at    = $signed({2'b00, atan_turn(5'(IDX))});
    assign trial = in_data.r + SQ_BIT;

    always_comb
    begin
        d_next = in_data;
        if (in_data.op == OP_ROTATE && IDX < ITERATIONS)
        begin
            if (!in_data.z[ZW-1])
            begin
                d_next.x = in_data.x - ys;
                d_next.y = in_data.y + xs;
                d_next.z = in_data.z - at;
            end
            else
            begin
                d_next.x = in_data.x + ys;
                d_next.y = in_data.y - xs;
                d_next.z = in_data.z + at;
            end
        end
        if (in_data.op == OP_LENGTH)
        begin
            if (in_data.n >= trial)
            begin
                d_next.n = in_data.n - trial;
                d_next.r = (in_data.r >> 1) + SQ_BIT;
            end
            else
                d_next.r = in_data.r >> 1;
        end
    end

    assign rdy      = !v_reg || out_ready;
    assign in_ready = rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && in_valid)
            d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

[design/v2au_post.sv]
// Output stages: gain removal, rounding, center add-back and clamp.
`timescale 1ns / 1ps
module v2au_post
    import v2au_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  stage_t       in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  out_xy,
    output logic         out_sat
);

    localparam logic signed [64:0] HALF28 = 65'sd134217728;
    localparam logic signed [63:0] HALF16 = 64'sd32768;

    logic               v1_reg, v2_reg, rdy1, rdy2;
    fin_t               f_reg, f_next;
    logic [63:0]        xy_reg, xy_next;
    logic               sat_reg, sat_next;
    logic signed [64:0] gx, gy;
    logic signed [63:0] px, py;
    logic [63:0]        rr;
    logic signed [VW-1:0] sx, sy;
    logic               ovx_p, ovx_n, ovy_p, ovy_n;

    assign gx = in_data.x * GAIN_INV;
    assign gy = in_data.y * GAIN_INV;
    assign px = $signed(in_data.n) + HALF16;
    assign py = $signed(in_data.r) + HALF16;
    assign rr = in_data.r + 64'(in_data.n > in_data.r);

    always_comb
    begin
        f_next = '0;
        case (in_data.op)
            OP_ADD, OP_SUB, OP_NEG:
            begin
                f_next.vx = VW'(in_data.x);
                f_next.vy = VW'(in_data.y);
            end
            OP_SCALE:
            begin
                f_next.vx = VW'(px >>> 16);
                f_next.vy = VW'(py >>> 16);
            end
            OP_LENGTH:
                f_next.vx = $signed({1'b0, rr[VW-2:0]});
            OP_ROTATE:
            begin
                f_next.vx = VW'((gx + HALF28) >>> 28);
                f_next.vy = VW'((gy + HALF28) >>> 28);
                f_next.bx = in_data.bx;
                f_next.by = in_data.by;
            end
            default: ;
        endcase
    end

    assign sx    = f_reg.vx + VW'(f_reg.bx);
    assign sy    = f_reg.vy + VW'(f_reg.by);
    assign ovx_p = !sx[VW-1] && (|sx[VW-2:31]);
    assign ovx_n = sx[VW-1] && !(&sx[VW-2:31]);
    assign ovy_p = !sy[VW-1] && (|sy[VW-2:31]);
    assign ovy_n = sy[VW-1] && !(&sy[VW-2:31]);

    always_comb
    begin
        xy_next[31:0]  = ovx_p ? 32'h7FFFFFFF : (ovx_n ? 32'h80000000 : sx[31:0]);
        xy_next[63:32] = ovy_p ? 32'h7FFFFFFF : (ovy_n ? 32'h80000000 : sy[31:0]);
        sat_next       = ovx_p || ovx_n || ovy_p || ovy_n;
    end

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            f_reg <= f_next;
        if (rdy2 && v1_reg)
        begin
            xy_reg  <= xy_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_xy    = xy_reg;
    assign out_sat   = sat_reg;

endmodule

[dv/testbench.sv]
// Self-checking testbench for the 2D vector arithmetic unit: directed table plus random words.
`timescale 1ns / 1ps
module testbench;
    import v2au_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int N_RANDOM = 1130;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_DEPTH = 36;
    localparam logic [31:0] MAXP = 32'h7FFFFFFF;
    localparam logic [31:0] MAXN = 32'h80000000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] ax, ay, bx, by, sf, ang;
    } vec_req_t;

    typedef struct {
        logic [31:0] rx, ry;
        logic        sat;
    } vec_res_t;

    typedef struct {
        vec_req_t req;
        bit       typed;
        vec_res_t res;
    } table_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // ax, ay, bx, by, scale_factor, angle
    logic [2:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // result_x, result_y
    logic         m_tuser;   // saturated

    vec_res_t    pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    table_row_t  dir_rows[$];

    // arctangent of 2^-k, in units of 2^-32 turn
    logic [31:0] atan_lut [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};

    vector_2d_arithmetic_unit #(.ITERATIONS(24)) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] clamp32(input longint v, inout logic f);
        if (v > 64'sd2147483647)
        begin
            f = 1'b1;
            return MAXP;
        end
        if (v < -64'sd2147483648)
        begin
            f = 1'b1;
            return MAXN;
        end
        return v[31:0];
    endfunction

    function automatic longint unsigned root_nearest(input longint unsigned n);
        longint unsigned acc;
        longint unsigned b;
        acc = 0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (n >= acc + b)
            begin
                n = n - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        if (n > acc)
            acc = acc + 1;
        return acc;
    endfunction

    // turn d by the quadrant exactly, then 24 CORDIC steps on the residual
    function automatic void cordic_turn(input longint dx, input longint dy,
                                        input logic [31:0] ang,
                                        output longint ox, output longint oy);
        logic [31:0] biased;
        logic [1:0]  quad;
        logic [31:0] resid;
        longint x, y, z, t, xs, ys;
        biased = ang + 32'h20000000;
        quad = biased[31:30];
        resid = ang - {quad, 30'd0};
        z = longint'($signed(resid));
        case (quad)
            2'd1: begin x = -dy; y = dx;  end
            2'd2: begin x = -dx; y = -dy; end
            2'd3: begin x = dy;  y = -dx; end
            default: begin x = dx; y = dy; end
        endcase
        x = x * 16;
        y = y * 16;
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> (i & 31);
            ys = y >>> (i & 31);
            if (z >= 0)
            begin
                t = x - ys; y = y + xs; z = z - longint'(atan_lut[i & 31]);
            end
            else
            begin
                t = x + ys; y = y - xs; z = z + longint'(atan_lut[i & 31]);
            end
            x = t;
        end
        ox = (x * 64'sd10188012 + (64'sd1 <<< 27)) >>> 28;
        oy = (y * 64'sd10188012 + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic vec_res_t predict_vector(input vec_req_t q);
        vec_res_t r;
        longint ax, ay, bx, by, sf, ox, oy;
        longint unsigned mx, my, len;
        logic f;
        ax = longint'($signed(q.ax));
        ay = longint'($signed(q.ay));
        bx = longint'($signed(q.bx));
        by = longint'($signed(q.by));
        sf = longint'($signed(q.sf));
        f = 1'b0;
        r.rx = '0;
        r.ry = '0;
        case (q.op)
            OP_ADD:
            begin
                r.rx = clamp32(ax + bx, f);
                r.ry = clamp32(ay + by, f);
            end
            OP_SUB:
            begin
                r.rx = clamp32(ax - bx, f);
                r.ry = clamp32(ay - by, f);
            end
            OP_NEG:
            begin
                r.rx = clamp32(-ax, f);
                r.ry = clamp32(-ay, f);
            end
            OP_SCALE:
            begin
                r.rx = clamp32((ax * sf + 32768) >>> 16, f);
                r.ry = clamp32((ay * sf + 32768) >>> 16, f);
            end
            OP_LENGTH:
            begin
                mx = (ax < 0) ? -ax : ax;
                my = (ay < 0) ? -ay : ay;
                len = root_nearest(mx * mx + my * my);
                if (len > 64'h7FFFFFFF)
                begin
                    len = 64'h7FFFFFFF;
                    f = 1'b1;
                end
                r.rx = len[31:0];
            end
            OP_ROTATE:
            begin
                cordic_turn(ax - bx, ay - by, q.ang, ox, oy);
                r.rx = clamp32(ox + bx, f);
                r.ry = clamp32(oy + by, f);
            end
            default: ;
        endcase
        r.sat = f;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR t=%0t %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // push one word and hold it until taken
    task automatic send_word(input vec_req_t q, input bit typed, input vec_res_t want);
        s_tvalid <= 1'b1;
        s_tuser  <= q.op;
        s_tdata  <= {q.ang, q.sf, q.by, q.bx, q.ay, q.ax};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(typed ? want : predict_vector(q));
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return MAXP;
            1: return MAXN;
            2: return 32'($signed($urandom_range(0, 200)) - 100);
            3, 4: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_req_t random_word();
        vec_req_t q;
        q.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
        q.ax = pick_coord();
        q.ay = pick_coord();
        q.bx = pick_coord();
        q.by = pick_coord();
        // keep most scale factors near unity so products stay in range
        q.sf = ($urandom_range(0, 2) == 0) ? pick_coord()
             : 32'($signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000);
        q.ang = $urandom;
        return q;
    endfunction

    function automatic table_row_t row(input logic [2:0] op, input logic [31:0] ax,
                                       input logic [31:0] ay, input logic [31:0] bx,
                                       input logic [31:0] by, input logic [31:0] sf,
                                       input logic [31:0] ang, input bit typed,
                                       input logic [31:0] rx, input logic [31:0] ry,
                                       input logic sat);
        table_row_t t;
        t.req = '{op, ax, ay, bx, by, sf, ang};
        t.typed = typed;
        t.res = '{rx, ry, sat};
        return t;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("ERROR t=%0t result word with nothing expected", $realtime);
                error_count++;
            end
            else
            begin
                vec_res_t w;
                w = pending_results.pop_front();
                if (m_tdata[31:0] !== w.rx)
                    report_mismatch("result_x", m_tdata[31:0], w.rx);
                if (m_tdata[63:32] !== w.ry)
                    report_mismatch("result_y", m_tdata[63:32], w.ry);
                if (m_tuser !== w.sat)
                    report_mismatch("saturated", {31'd0, m_tuser}, {31'd0, w.sat});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL vector_2d_arithmetic_unit");
            $finish;
        end
    end

    // receiver: alternating free-running and choppy stretches, with one long hold-off
    initial
    begin
        int rcv_cycles;
        rcv_cycles = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rcv_cycles++;
            if (rcv_cycles == 600)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                rcv_cycles = rcv_cycles + 300;
            end
            if ((rcv_cycles / 400) % 3 == 0)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        vec_res_t none;
        int sent;
        int burst;
        int gap;
        none = '{32'd0, 32'd0, 1'b0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;

        dir_rows.push_back(row(OP_ADD, MAXP, MAXN, 32'd1, MAXN, 0, 0, 1, MAXP, MAXN, 1));
        dir_rows.push_back(row(OP_ADD, 32'h10000, 32'hFFFF0000, 32'h20000, 32'h10000, 0, 0,
                               1, 32'h30000, 32'd0, 0));
        dir_rows.push_back(row(OP_SUB, MAXN, MAXP, 32'd1, MAXN, 0, 0, 1, MAXN, MAXP, 1));
        dir_rows.push_back(row(OP_SUB, 32'd5, 32'd7, 32'd2, 32'd9, 0, 0, 1, 32'd3, 32'hFFFFFFFE, 0));
        dir_rows.push_back(row(OP_NEG, MAXN, MAXP, 0, 0, 0, 0, 1, MAXP, 32'h80000001, 1));
        dir_rows.push_back(row(OP_NEG, 32'd0, 32'd1, MAXP, MAXN, MAXP, MAXP, 1, 32'd0, 32'hFFFFFFFF, 0));
        dir_rows.push_back(row(OP_SCALE, 32'd5, 32'hFFFFFFFB, 0, 0, 32'h10000, 0,
                               1, 32'd5, 32'hFFFFFFFB, 0));
        dir_rows.push_back(row(OP_SCALE, MAXP, MAXN, 0, 0, MAXP, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_SCALE, MAXN, MAXN, 0, 0, MAXN, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_SCALE, 32'h12345, 32'hFFFF8000, 0, 0, 32'h00008000, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_LENGTH, 32'h30000, 32'hFFFC0000, 0, 0, 0, 0, 1, 32'h50000, 0, 0));
        dir_rows.push_back(row(OP_LENGTH, MAXN, MAXN, 0, 0, 0, 0, 1, MAXP, 32'd0, 1));
        dir_rows.push_back(row(OP_LENGTH, 32'd0, 32'd0, 0, 0, 0, 0, 1, 32'd0, 32'd0, 0));
        dir_rows.push_back(row(OP_LENGTH, MAXP, 32'd0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, 32'h10000, 0, 0, 0, 0, 32'h00000000, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, 32'h10000, 0, 0, 0, 0, 32'h40000000, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, 32'h10000, 32'h20000, 32'h8000, 0, 0, 32'h80000000,
                               0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, 32'h10000, 0, 0, 0, 0, 32'h1FFFFFFF, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, 32'h10000, 0, 0, 0, 0, 32'hE0000000, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, MAXP, MAXP, MAXN, MAXN, 0, 32'hFFFFFFFF, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_ROTATE, MAXN, MAXP, MAXP, MAXN, 0, 32'h60000000, 0, 0, 0, 0));
        dir_rows.push_back(row(OP_SPARE6, MAXP, MAXN, MAXP, MAXN, MAXP, MAXP, 1, 0, 0, 0));
        dir_rows.push_back(row(OP_SPARE7, MAXN, MAXP, MAXN, MAXP, MAXN, 0, 1, 0, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        s_tvalid <= 1'b0;

        // drain fully before the random part
        while (pending_results.size() != 0)
            @(negedge clk);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                send_word(random_word(), 1'b0, none);
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2 * PIPE_DEPTH) @(negedge clk);

        if (error_count == 0)
            $display("PASS vector_2d_arithmetic_unit");
        else
            $display("FAIL vector_2d_arithmetic_unit");
        $finish;
    end

endmodule

[vector_2d_arithmetic_unit.f]
design/v2au_pkg.sv
design/v2au_prep.sv
design/v2au_cell.sv
design/v2au_post.sv
design/vector_2d_arithmetic_unit.sv
dv/testbench.sv
